[hdl/zpcc_pkg.sv]
// Package: constants, types and controller states for the z-score peak cycle counter.
package zpcc_pkg;
  localparam int LAG = 32;
  localparam int PTR_W = (LAG > 1) ? $clog2(LAG) : 1;
  localparam int CNT_W = $clog2(LAG + 1);
  localparam int SUM_W = 16 + $clog2(LAG) + 1;
  localparam int SQ_W = 32 + $clog2(LAG) + 1;
  localparam logic [23:0] CYCLE_MAX = 24'hFFFFFF;
  localparam logic [16:0] INFL_ONE = 17'h10000;
  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_INFLUENCE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MUL1, ST_MUL2, ST_MUL3, ST_CMP, ST_UPDATE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic mul1;
    logic mul2;
    logic mul3;
    logic cmp;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic warm;
  } stat_t;
endpackage

[hdl/zpcc_ram.sv]
// Generic single-port RAM with registered read.
module zpcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[hdl/zpcc_ctrl.sv]
// Controller state machine sequencing one item through the datapath.
module zpcc_ctrl import zpcc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_nxt = stat.warm ? ST_UPDATE : ST_MUL1;
      end
      ST_MUL1: begin cmd.mul1 = 1'b1; state_nxt = ST_MUL2; end
      ST_MUL2: begin cmd.mul2 = 1'b1; state_nxt = ST_MUL3; end
      ST_MUL3: begin cmd.mul3 = 1'b1; state_nxt = ST_CMP; end
      ST_CMP: begin cmd.cmp = 1'b1; state_nxt = ST_UPDATE; end
      ST_UPDATE: begin cmd.update = 1'b1; state_nxt = ST_OUT; end
      ST_OUT: begin
        out_valid = 1'b1;
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[hdl/zpcc_dp.sv]
// Datapath: window RAM, running sums, multipliers, history and counter.
module zpcc_dp import zpcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic signed [15:0] sample,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_addr,
  input  logic [16:0]        cfg_wdata,
  output logic signed [1:0]  peak_signal,
  output logic [23:0]        cycle_count,
  output logic               window_full
);
  logic [15:0] thr_r;
  logic [16:0] infl_r;
  logic [PTR_W-1:0] ptr_r;
  logic [CNT_W-1:0] warm_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0] sq_r;
  logic signed [15:0] last_r, s_r, old;
  logic signed [SUM_W+PTR_W:0] d_r;
  logic [SQ_W+PTR_W:0] v_r;
  logic [71:0] lhs_r;
  logic [31:0] t2_r;
  logic [53:0] rlo_r;
  logic [79:0] rhs_r;
  logic flag_r;
  logic signed [15:0] blend_r;
  logic signed [1:0] h1_r, h2_r, stat_r;
  logic [23:0] cnt_r;
  logic signed [15:0] f;
  logic signed [35:0] acc;
  logic [35:0] accu;
  logic [16:0] w;
  logic signed [1:0] st;
  logic [SUM_W-1:0] asum;
  logic [SUM_W+PTR_W:0] ad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd896;
      infl_r <= 17'd32768;
    end else if (cfg_we) begin
      if (cfg_addr == REG_THRESHOLD) thr_r <= cfg_wdata[15:0];
      else if (cfg_addr == REG_INFLUENCE) infl_r <= cfg_wdata;
    end
  end

  assign f = flag_r ? blend_r : s_r;
  zpcc_ram #(.WIDTH(16), .DEPTH(LAG)) u_ram (
    .clk(clk), .we(cmd.update), .addr(ptr_r), .wdata(f), .rdata(old));

  assign stat.warm = warm_r < CNT_W'(LAG);
  assign asum = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign ad = d_r[SUM_W+PTR_W] ? -d_r : d_r;
  assign w = (infl_r > INFL_ONE) ? INFL_ONE : infl_r;
  assign acc = $signed({19'd0, w}) * s_r + $signed({19'd0, INFL_ONE - w}) * last_r;
  assign accu = 36'(acc + 36'sh80008000);
  assign st = flag_r ? (d_r > 0 ? 2'sd1 : -2'sd1) : 2'sd0;

  always_ff @(posedge clk) begin
    if (cmd.load) s_r <= sample;
    if (cmd.rd) d_r <= (SUM_W+PTR_W+1)'((SUM_W+PTR_W+1)'(s_r) * LAG - sum_r);
    if (cmd.mul1) begin
      v_r <= (SQ_W+PTR_W+1)'(sq_r) * LAG - (SQ_W+PTR_W+1)'(asum * asum);
      t2_r <= thr_r * thr_r;
    end
    if (cmd.mul2) begin
      lhs_r <= 72'(ad * ad) << 16;
      rlo_r <= 54'(t2_r * v_r[21:0]);
    end
    if (cmd.mul3) rhs_r <= 80'(rlo_r) + (80'(t2_r * v_r[SQ_W+PTR_W:22]) << 22);
    if (cmd.cmp) blend_r <= accu[31:16] ^ 16'h8000;
    if (!rst_n) flag_r <= 1'b0;
    else if (cmd.cmp) flag_r <= 80'(lhs_r) > rhs_r;
    else if (cmd.load) flag_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0; warm_r <= '0; sum_r <= '0; sq_r <= '0; last_r <= '0;
      h1_r <= '0; h2_r <= '0; cnt_r <= '0; stat_r <= '0;
    end else if (cmd.update) begin
      sum_r <= sum_r + SUM_W'(f) - (stat.warm ? SUM_W'(0) : SUM_W'(old));
      sq_r <= sq_r + SQ_W'(32'(f * f)) - (stat.warm ? SQ_W'(0) : SQ_W'(32'(old * old)));
      ptr_r <= (ptr_r == PTR_W'(LAG - 1)) ? '0 : ptr_r + 1'b1;
      last_r <= f;
      if (stat.warm) begin
        warm_r <= warm_r + 1'b1;
        stat_r <= '0;
      end else begin
        stat_r <= st;
        if (st != h2_r) begin
          h1_r <= h2_r; h2_r <= st;
          if (h1_r == 2'sd1 && h2_r == 2'sd0 && st == -2'sd1 && cnt_r != CYCLE_MAX)
            cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign peak_signal = stat_r;
  assign cycle_count = cnt_r;
  assign window_full = !stat.warm;
endmodule

[hdl/zscore_peak_cycle_counter_top.sv]
// Top level of the z-score peak detector with cycle counter.
// From accept to out_valid the controller passes READ, UPDATE, OUT in warm-up and READ, MUL1,
// MUL2, MUL3, CMP, UPDATE, OUT after it; the multiply and compare steps set the item rate.
// Next item accepted in the cycle its result is taken; a waiting result holds off the input.
// Synchronous active-low reset clears pointers, sums, history and counter and loads the
// register reset values; the window RAM is not cleared.
module zscore_peak_cycle_counter_top import zpcc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [1:0]  out_peak_signal,
  output logic [23:0]        out_cycle_count,
  output logic               out_window_full,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_addr,
  input  logic [16:0]        cfg_wdata
);
  cmd_t cmd;
  stat_t stat;
  zpcc_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd));
  zpcc_dp u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .sample(in_sample),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .peak_signal(out_peak_signal), .cycle_count(out_cycle_count),
    .window_full(out_window_full));

  a_out_pk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_full |-> out_peak_signal == 2'sd0) else $error("warmup peak");
  a_pk_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_signal != -2'sd2) else $error("bad peak");
  a_cnt_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> out_cycle_count >= $past(out_cycle_count)) else $error("cnt");
endmodule
